/* rtl/iira_pkg.sv */
`default_nettype none

package iira_pkg;

   // Array geometry
   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int POS_W  = 7;
   localparam int WORD_W = 64;

   localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

   // Request codes
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_GET    = 3'd3,
      OP_RESIZE = 3'd4,
      OP_CLEAR  = 3'd5
   } op_code_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Per-cycle command broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_TRUNC,
      CELL_CLEAR
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type             mode;
      logic [POS_W-1:0]          pos;
      logic [POS_W-1:0]          count;
      logic signed [WORD_W-1:0]  word;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]                req_type;
      logic [POS_W-1:0]          position;
      logic signed [WORD_W-1:0]  data_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  read_value;
      logic [1:0]                status;
      logic [POS_W-1:0]          count;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/iira_cell.sv */
`default_nettype none

module iira_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [iira_pkg::IDX_W-1:0]        cell_index,
   input  wire iira_pkg::cell_ctl_type            ctl,
   input  wire logic signed [iira_pkg::WORD_W-1:0] left_value,
   input  wire logic signed [iira_pkg::WORD_W-1:0] right_value,
   output logic signed [iira_pkg::WORD_W-1:0]      value,
   output logic signed [iira_pkg::WORD_W-1:0]      hit_value
);
   import iira_pkg::*;

   logic signed [WORD_W-1:0] value_ff;
   logic signed [WORD_W-1:0] value_in;
   logic [POS_W-1:0]         idx;
   logic [POS_W-1:0]         idx_next;

   assign idx      = POS_W'(cell_index);
   assign idx_next = idx + POS_W'(1);

   // Next value from the broadcast command and the neighbors
   always_comb begin
      value_in = value_ff;
      case (ctl.mode)
         CELL_INSERT: begin
            if (idx == ctl.pos) begin
               value_in = ctl.word;
            end else if (idx > ctl.pos && idx <= ctl.count) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (idx >= ctl.pos && idx_next < ctl.count) begin
               value_in = right_value;
            end else if (idx_next == ctl.count) begin
               value_in = '0;
            end
         end
         CELL_TRUNC: begin
            if (idx >= ctl.pos) begin
               value_in = '0;
            end
         end
         CELL_CLEAR: value_in = '0;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value     = value_ff;
   // Only the addressed cell puts its word on the read bus
   assign hit_value = (idx == ctl.pos) ? value_ff : '0;

endmodule

`default_nettype wire

/* rtl/indexed_insert_remove_array.sv */
`default_nettype none
// Each accepted request's result is registered and valid in the next cycle.
// One transaction per cycle unless req_stall; every cell shifts in the same cycle.
// The result register frees as soon as its transaction is taken.
// Reset (synchronous) clears the count and all cells.

module indexed_insert_remove_array (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire iira_pkg::req_payload_type  req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output iira_pkg::rsp_payload_type       rsp_payload
);
   import iira_pkg::*;

   logic                     req_fire;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_payload_ff;
   rsp_payload_type          rsp_payload_in;
   logic [POS_W-1:0]         count_ff;
   logic [POS_W-1:0]         count_in;
   cell_ctl_type             ctl;
   logic [1:0]               status;
   logic                     is_get;
   logic signed [WORD_W-1:0] read_bus;

   logic signed [WORD_W-1:0] cell_value [DEPTH];
   logic signed [WORD_W-1:0] hit_value  [DEPTH];

   // Handshake: take a new transaction unless the result register is blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   // Request decode into a broadcast command
   always_comb begin
      ctl.mode  = CELL_HOLD;
      ctl.pos   = req_payload.position;
      ctl.count = count_ff;
      ctl.word  = req_payload.data_value;
      count_in  = count_ff;
      status    = ST_OK;
      is_get    = 1'b0;
      case (req_payload.req_type)
         OP_PUSH, OP_INSERT: begin
            if (count_ff == DEPTH_POS) begin
               status = ST_FULL;
            end else begin
               ctl.mode = CELL_INSERT;
               if (req_payload.req_type == OP_PUSH || req_payload.position >= count_ff) begin
                  ctl.pos = count_ff;
               end
               count_in = count_ff + POS_W'(1);
            end
         end
         OP_REMOVE: begin
            if (req_payload.position >= count_ff) begin
               status = ST_BAD;
            end else begin
               ctl.mode = CELL_REMOVE;
               count_in = count_ff - POS_W'(1);
            end
         end
         OP_GET: begin
            if (req_payload.position >= count_ff) begin
               status = ST_BAD;
            end else begin
               is_get = 1'b1;
            end
         end
         OP_RESIZE: begin
            if (req_payload.position > DEPTH_POS) begin
               status = ST_FULL;
            end else begin
               // cells at or past the count are always zero, so only truncation writes
               ctl.mode = CELL_TRUNC;
               count_in = req_payload.position;
            end
         end
         OP_CLEAR: begin
            ctl.mode = CELL_CLEAR;
            count_in = '0;
         end
         default: status = ST_OK;
      endcase
      if (!req_fire) begin
         ctl.mode = CELL_HOLD;
      end
   end

   // Row of cells, each linked to its left and right neighbors where they exist
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_w;
      logic signed [WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = cell_value[i+1];
      end
      iira_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .ctl         (ctl),
         .left_value  (left_w),
         .right_value (right_w),
         .value       (cell_value[i]),
         .hit_value   (hit_value[i])
      );
   end

   // Read bus: at most one cell matches the position
   always_comb begin
      read_bus = '0;
      for (int k = 0; k < DEPTH; k++) begin
         read_bus = read_bus | hit_value[k];
      end
   end

   always_comb begin
      rsp_payload_in.read_value = is_get ? read_bus : '0;
      rsp_payload_in.status     = status;
      rsp_payload_in.count      = count_in;
   end

   // Fill count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_POS)
      else $error("fill count above capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.count == count_ff)
      else $error("reported count differs from fill count");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.status != ST_OK |-> rsp_payload_ff.read_value == '0)
      else $error("failed transaction returned data");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.req_type == OP_CLEAR |=> count_ff == '0 && cell_value[0] == '0)
      else $error("clear left data behind");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> cell_value[0] == '0)
      else $error("empty array holds a nonzero word");

endmodule

`default_nettype wire

/* bench/indexed_insert_remove_array_test.sv */
module indexed_insert_remove_array_test;
   timeunit 1ns;
   timeprecision 1ps;

   import iira_pkg::*;

   // Request codes the block leaves unused
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic signed [WORD_W-1:0] WORD_ZERO = '0;
   localparam logic signed [WORD_W-1:0] WORD_ONES = '1;
   localparam logic signed [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_FIVES = 64'h5555_5555_5555_5555;
   localparam logic signed [WORD_W-1:0] WORD_TENS  = 64'hAAAA_AAAA_AAAA_AAAA;

   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 240;

   // One directed transaction; the want_* fields hold only when fixed is set
   typedef struct packed {
      logic [2:0]               kind;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;
      logic                     fixed;
      logic signed [WORD_W-1:0] want_value;
      status_type               want_status;
      logic [POS_W-1:0]         want_count;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_GET,     7'd0,      WORD_ZERO,  1'b1, WORD_ZERO, ST_BAD,  7'd0},
      '{OP_REMOVE,  7'd0,      WORD_ZERO,  1'b1, WORD_ZERO, ST_BAD,  7'd0},
      '{OP_PUSH,    7'd0,      WORD_MAX,   1'b1, WORD_ZERO, ST_OK,   7'd1},
      '{OP_PUSH,    POS_MAX,   WORD_MIN,   1'b1, WORD_ZERO, ST_OK,   7'd2},
      '{OP_INSERT,  7'd0,      WORD_ONES,  1'b1, WORD_ZERO, ST_OK,   7'd3},
      '{OP_INSERT,  7'd1,      WORD_FIVES, 1'b0, WORD_ZERO, ST_OK,   7'd0},
      '{OP_INSERT,  POS_MAX,   WORD_TENS,  1'b1, WORD_ZERO, ST_OK,   7'd5},
      '{OP_GET,     7'd0,      WORD_ZERO,  1'b1, WORD_ONES, ST_OK,   7'd5},
      '{OP_GET,     7'd4,      WORD_ONES,  1'b1, WORD_TENS, ST_OK,   7'd5},
      '{OP_GET,     7'd5,      WORD_ZERO,  1'b1, WORD_ZERO, ST_BAD,  7'd5},
      '{OP_REMOVE,  7'd1,      WORD_ZERO,  1'b0, WORD_ZERO, ST_OK,   7'd0},
      '{OP_REMOVE,  POS_MAX,   WORD_ZERO,  1'b1, WORD_ZERO, ST_BAD,  7'd4},
      '{OP_RESIZE,  DEPTH_POS, WORD_ZERO,  1'b1, WORD_ZERO, ST_OK,   DEPTH_POS},
      '{OP_GET,     7'd63,     WORD_ZERO,  1'b1, WORD_ZERO, ST_OK,   DEPTH_POS},
      '{OP_PUSH,    7'd0,      WORD_ONES,  1'b1, WORD_ZERO, ST_FULL, DEPTH_POS},
      '{OP_INSERT,  7'd0,      WORD_ONES,  1'b1, WORD_ZERO, ST_FULL, DEPTH_POS},
      '{OP_RESIZE,  7'd65,     WORD_ZERO,  1'b1, WORD_ZERO, ST_FULL, DEPTH_POS},
      '{OP_RESIZE,  7'd2,      WORD_ZERO,  1'b1, WORD_ZERO, ST_OK,   7'd2},
      '{OP_GET,     7'd1,      WORD_ZERO,  1'b0, WORD_ZERO, ST_OK,   7'd0},
      '{OP_RESIZE,  7'd5,      WORD_ZERO,  1'b1, WORD_ZERO, ST_OK,   7'd5},
      '{OP_GET,     7'd4,      WORD_ZERO,  1'b1, WORD_ZERO, ST_OK,   7'd5},
      '{OP_SPARE_6, POS_MAX,   WORD_ONES,  1'b1, WORD_ZERO, ST_OK,   7'd5},
      '{OP_SPARE_7, 7'd0,      WORD_MIN,   1'b1, WORD_ZERO, ST_OK,   7'd5},
      '{OP_CLEAR,   POS_MAX,   WORD_ONES,  1'b1, WORD_ZERO, ST_OK,   7'd0},
      '{OP_RESIZE,  7'd0,      WORD_ZERO,  1'b1, WORD_ZERO, ST_OK,   7'd0}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Shadow copy of the array contents
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int shadow_fill = 0;
   bit filling = 1'b1;

   rsp_payload_type expected_results [$];
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   indexed_insert_remove_array i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // Apply one request to the shadow array and return the result it should give
   function automatic rsp_payload_type apply_array_request(input req_payload_type p);
      rsp_payload_type r;
      int at;
      int i;
      r.read_value = '0;
      r.status = ST_OK;
      case (p.req_type)
         OP_PUSH, OP_INSERT: begin
            if (shadow_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               at = (p.req_type == OP_PUSH || int'(p.position) >= shadow_fill) ?
                    shadow_fill : int'(p.position);
               for (i = shadow_fill; i > at; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[at] = p.data_value;
               shadow_fill++;
            end
         end
         OP_REMOVE: begin
            if (int'(p.position) >= shadow_fill) begin
               r.status = ST_BAD;
            end else begin
               for (i = int'(p.position); i + 1 < shadow_fill; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_words[shadow_fill-1] = '0;
               shadow_fill--;
            end
         end
         OP_GET: begin
            if (int'(p.position) >= shadow_fill) r.status = ST_BAD;
            else r.read_value = shadow_words[p.position[IDX_W-1:0]];
         end
         OP_RESIZE: begin
            if (int'(p.position) > DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // cells between old and new count end up zero either way
               for (i = 0; i < DEPTH; i++)
                  if ((i >= int'(p.position) && i < shadow_fill) ||
                      (i >= shadow_fill && i < int'(p.position)))
                     shadow_words[i] = '0;
               shadow_fill = int'(p.position);
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < DEPTH; i++) shadow_words[i] = '0;
            shadow_fill = 0;
         end
         default: ;
      endcase
      r.count = POS_W'(shadow_fill);
      return r;
   endfunction

   // Random request, biased to fill the array up to full and then drain it
   function automatic req_payload_type make_random_request();
      req_payload_type p;
      int pick;
      int r;
      if (shadow_fill == DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
      if (shadow_fill <= 1) filling = 1'b1;

      pick = $urandom_range(0, 99);
      if (filling) begin
         if (pick < 30)      p.req_type = OP_PUSH;
         else if (pick < 55) p.req_type = OP_INSERT;
         else if (pick < 67) p.req_type = OP_REMOVE;
         else if (pick < 89) p.req_type = OP_GET;
         else if (pick < 95) p.req_type = OP_RESIZE;
         else if (pick < 97) p.req_type = OP_CLEAR;
         else                p.req_type = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end else begin
         if (pick < 10)      p.req_type = OP_PUSH;
         else if (pick < 20) p.req_type = OP_INSERT;
         else if (pick < 55) p.req_type = OP_REMOVE;
         else if (pick < 82) p.req_type = OP_GET;
         else if (pick < 95) p.req_type = OP_RESIZE;
         else if (pick < 97) p.req_type = OP_CLEAR;
         else                p.req_type = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end

      // mostly in range, sometimes at the end, sometimes anywhere
      r = $urandom_range(0, 9);
      if (r < 7)
         p.position = (shadow_fill == 0) ? '0 : POS_W'($urandom_range(0, shadow_fill - 1));
      else if (r == 7)
         p.position = POS_W'(shadow_fill);
      else
         p.position = POS_W'($urandom_range(0, 127));
      if (p.req_type == OP_RESIZE && $urandom_range(0, 3) != 0)
         p.position = filling ? POS_W'($urandom_range(shadow_fill, DEPTH)) :
                                POS_W'($urandom_range(0, shadow_fill));

      r = $urandom_range(0, 15);
      case (r)
         0:       p.data_value = WORD_MAX;
         1:       p.data_value = WORD_MIN;
         2:       p.data_value = WORD_ZERO;
         3:       p.data_value = WORD_ONES;
         default: p.data_value = {$urandom, $urandom};
      endcase
      return p;
   endfunction

   // Drive one transaction; on acceptance queue what it should return
   task automatic send_request(input req_payload_type p, input bit fixed,
                               input rsp_payload_type want);
      rsp_payload_type predicted;
      while ($urandom_range(1, 100) <= sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_array_request(p);
      expected_results.push_back(fixed ? want : predicted);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Result check and receiver stall
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected: value %0d status %0d count %0d",
                   rsp_payload.read_value, rsp_payload.status, rsp_payload.count);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value,
                      rsp_payload.read_value);
               mismatch_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_payload.count);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(1, 100) <= receiver_stall_pct);
   end

   // Stimulus
   initial begin
      req_payload_type p;
      rsp_payload_type want;
      int n;
      int k;
      for (n = 0; n < DEPTH; n++) shadow_words[n] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         p.req_type   = directed_rows[n].kind;
         p.position   = directed_rows[n].pos;
         p.data_value = directed_rows[n].word;
         want.read_value = directed_rows[n].want_value;
         want.status     = directed_rows[n].want_status;
         want.count      = directed_rows[n].want_count;
         send_request(p, directed_rows[n].fixed, want);
      end
      drain_results();

      // random phases, idling pattern changes each phase
      for (n = 0; n < RANDOM_PHASES; n++) begin
         case (n % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
            default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
         endcase
         for (k = 0; k < ITEMS_PER_PHASE; k++)
            send_request(make_random_request(), 1'b0, '0);
         // hold off until the block has returned everything
         drain_results();
      end

      receiver_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("indexed_insert_remove_array_test passed");
      else
         $display("indexed_insert_remove_array_test failed");
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("indexed_insert_remove_array_test failed");
      $finish;
   end

endmodule
